>>> rtl/bfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared constants, register indexes and types of the boid flocking update.
// ----------------------------------------------------------------------------
package bfu_pkg;

  localparam int BOID_COUNT_DEF     = 128;
  localparam int NEIGHBOR_COUNT_DEF = 4;
  localparam int IDX_W              = 7;
  localparam int DATA_W             = 32;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 31;
  localparam int DIST_W             = 34;
  localparam logic signed [DATA_W-1:0] EDGE_LOW_BOUND = 32'sd33554432;

  localparam logic [CFG_IDX_W-1:0] REG_COH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALI    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAXS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd7;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         sel_index;
    logic signed [DATA_W-1:0] load_pos_x;
    logic signed [DATA_W-1:0] load_pos_y;
    logic signed [DATA_W-1:0] load_vel_x;
    logic signed [DATA_W-1:0] load_vel_y;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
  } out_item_t;

  // candidate travelling down the sorting row
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] gap;
    logic [10:0]       id;
  } cand_t;

endpackage

>>> rtl/bfu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfu_in_if / bfu_out_if
// Valid/ready channels for load/update items and for results.
// ----------------------------------------------------------------------------
interface bfu_in_if;
  import bfu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bfu_out_if;
  import bfu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/boid_flocking_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boid_flocking_update
// Boid state store, neighbor search over a row of sorting cells, and the
// cohesion / separation / alignment / speed-limit / edge-push update.
//
// channel  dir  transfer
// in       in   func, sel_index, load_pos_x/y, load_vel_x/y
// out      out  out_index, new_pos_x/y, new_vel_x/y
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A load writes the store and returns the loaded item. An update reads the
// boid itself, feeds the cell row with one store read per boid, reads each
// neighbor back and finishes the velocity in the sum/limit/shift/push steps.
// Reset clears control and loads the configuration defaults; the boid store holds no reset.
// One item is in work at a time; a held result stalls the next start.
// ----------------------------------------------------------------------------
module boid_flocking_update #(
  parameter int BOID_COUNT     = bfu_pkg::BOID_COUNT_DEF,
  parameter int NEIGHBOR_COUNT = bfu_pkg::NEIGHBOR_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bfu_in_if.sink                          in_ch,
  bfu_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfu_pkg::*;

  localparam int AW   = (BOID_COUNT > 1) ? $clog2(BOID_COUNT) : 1;
  localparam int NW   = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;
  localparam int MS   = $clog2(NEIGHBOR_COUNT + 1) - 1;
  localparam int CW   = ((AW > 5) ? AW : 5) + 1;
  localparam int WW   = 48;
  localparam int LATE = NEIGHBOR_COUNT + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RD_SELF, S_SELF, S_SCAN, S_DRAIN, S_NB_RD, S_NB_ACC,
    S_SUM, S_LIMIT, S_SHIFT, S_PUSH, S_WRITE, S_OUT
  } state_t;

  // configuration
  logic [4:0]  coh_r, sep_r, ali_r, maxs_r;
  logic [30:0] rad_r, right_r, bottom_r;
  logic [23:0] push_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coh_r <= 5'd6; sep_r <= 5'd4; ali_r <= 5'd2; maxs_r <= 5'd22;
      rad_r <= 31'd10485760; push_r <= 24'd1048576;
      right_r <= 31'd637534208; bottom_r <= 31'd469762048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COH:    coh_r    <= cfg_data[4:0];
        REG_SEP:    sep_r    <= cfg_data[4:0];
        REG_ALI:    ali_r    <= cfg_data[4:0];
        REG_MAXS:   maxs_r   <= cfg_data[4:0];
        REG_RAD:    rad_r    <= cfg_data;
        REG_PUSH:   push_r   <= cfg_data[23:0];
        REG_RIGHT:  right_r  <= cfg_data;
        REG_BOTTOM: bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // boid store
  logic [4*DATA_W-1:0] mem [BOID_COUNT];
  logic                mem_we;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [4*DATA_W-1:0] mem_wd, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  logic signed [DATA_W-1:0] rd_px, rd_py, rd_vx, rd_vy;
  assign {rd_px, rd_py, rd_vx, rd_vy} = mem_rd_r;

  // control
  state_t        state_r;
  in_item_t      item_r;
  logic [CW-1:0] cnt_r;
  logic          scan_rd_r, out_valid_r;
  out_item_t     out_r;

  logic signed [DATA_W-1:0] sx_r, sy_r, svx_r, svy_r;
  logic signed [WW-1:0] cx_r, cy_r, rx_r, ry_r, mx_r, my_r, ax_r, ay_r;
  logic [5:0]  sh_r;
  logic [NW:0] nb_r;
  logic [DIST_W-1:0] nd_r;
  logic nb_close_r;

  // cell row
  cand_t chain [NEIGHBOR_COUNT+1];
  cand_t held  [NEIGHBOR_COUNT];
  logic  row_clear;
  logic signed [DATA_W:0] ddx, ddy;
  logic [DIST_W-1:0] span;

  assign ddx  = {sx_r[DATA_W-1], sx_r} - {rd_px[DATA_W-1], rd_px};
  assign ddy  = {sy_r[DATA_W-1], sy_r} - {rd_py[DATA_W-1], rd_py};
  assign span = DIST_W'(ddx[DATA_W] ? -ddx : ddx) + DIST_W'(ddy[DATA_W] ? -ddy : ddy);

  assign row_clear = (state_r == S_SELF);
  always_comb begin
    chain[0].valid = scan_rd_r;
    chain[0].gap   = span;
    chain[0].id    = 11'(cnt_r - CW'(1));
  end

  genvar g;
  generate
    for (g = 0; g < NEIGHBOR_COUNT; g++) begin : g_cell
      bfu_cell u_cell (
        .clk(clk), .clear(row_clear), .cand_in(chain[g]),
        .cand_out(chain[g+1]), .held(held[g])
      );
    end
  endgenerate

  // neighbor pick
  cand_t cur_nb;
  always_comb begin
    cur_nb = '0;
    for (int i = 0; i < NEIGHBOR_COUNT; i++)
      if (nb_r == (NW+1)'(i)) cur_nb = held[i];
  end

  function automatic logic signed [WW-1:0] asr_w(logic signed [WW-1:0] v, logic [5:0] s);
    return v >>> s;
  endfunction

  function automatic logic [5:0] flog2(logic [WW-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < WW; i++)
      if (v[i]) r = 6'(i);
    return r;
  endfunction

  logic [WW-1:0] speed;
  logic [5:0] mg;
  assign speed = (ax_r[WW-1] ? -ax_r : ax_r) + (ay_r[WW-1] ? -ay_r : ay_r);
  assign mg    = flog2(speed);

  logic signed [WW-1:0] pushw;
  assign pushw = WW'(push_r);

  logic signed [DATA_W-1:0] nvx, nvy;
  assign nvx = ax_r[DATA_W-1:0];
  assign nvy = ay_r[DATA_W-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = item_r.sel_index[AW-1:0];
    mem_wd = {item_r.load_pos_x, item_r.load_pos_y, item_r.load_vel_x, item_r.load_vel_y};
    mem_ra = item_r.sel_index[AW-1:0];
    if (state_r == S_LOAD) mem_we = 1'b1;
    if (state_r == S_WRITE) begin
      mem_we = 1'b1;
      mem_wd = {sx_r + nvx, sy_r + nvy, nvx, nvy};
    end
    if (state_r == S_SCAN) mem_ra = cnt_r[AW-1:0];
    if (state_r == S_NB_RD) mem_ra = cur_nb.id[AW-1:0];
  end

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  logic in_ok;
  assign in_ok = (32'(in_ch.data.sel_index) < BOID_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      scan_rd_r   <= 1'b0;
      cnt_r       <= '0;
      nb_r        <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      scan_rd_r <= (state_r == S_SCAN);
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          item_r <= in_ch.data;
          if (!in_ok) begin
            out_r <= {in_ch.data.sel_index, {(4*DATA_W){1'b0}}};
            out_valid_r <= 1'b1;
          end else if (in_ch.data.func == FUNC_LOAD) state_r <= S_LOAD;
          else state_r <= S_RD_SELF;
        end
        S_LOAD: begin
          out_r <= {item_r.sel_index, item_r.load_pos_x, item_r.load_pos_y,
                    item_r.load_vel_x, item_r.load_vel_y};
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_RD_SELF: state_r <= S_SELF;
        S_SELF: begin
          sx_r <= rd_px; sy_r <= rd_py; svx_r <= rd_vx; svy_r <= rd_vy;
          cnt_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(BOID_COUNT - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          cnt_r <= '0;
          state_r <= S_NB_RD;
          cx_r <= '0; cy_r <= '0; rx_r <= '0; ry_r <= '0; mx_r <= '0; my_r <= '0;
          nb_r <= '0;
        end
        S_NB_RD: begin
          // wait for row to settle, then read neighbor
          if (cnt_r < CW'(LATE)) cnt_r <= cnt_r + CW'(1);
          else if (32'(nb_r) >= NEIGHBOR_COUNT || !cur_nb.valid) state_r <= S_SUM;
          else begin
            nd_r <= cur_nb.gap;
            state_r <= S_NB_ACC;
          end
        end
        S_NB_ACC: begin
          cx_r <= cx_r + (WW'(rd_px) >>> MS);
          cy_r <= cy_r + (WW'(rd_py) >>> MS);
          mx_r <= mx_r + (WW'(rd_vx) >>> MS);
          my_r <= my_r + (WW'(rd_vy) >>> MS);
          if (nd_r < DIST_W'(rad_r)) begin
            rx_r <= rx_r + WW'(sx_r) - WW'(rd_px);
            ry_r <= ry_r + WW'(sy_r) - WW'(rd_py);
          end
          nb_r <= nb_r + (NW+1)'(1);
          state_r <= S_NB_RD;
        end
        S_SUM: begin
          ax_r <= WW'(svx_r) + asr_w(cx_r - WW'(sx_r), {1'b0, coh_r})
                  + asr_w(rx_r, {1'b0, sep_r}) + asr_w(mx_r, {1'b0, ali_r});
          ay_r <= WW'(svy_r) + asr_w(cy_r - WW'(sy_r), {1'b0, coh_r})
                  + asr_w(ry_r, {1'b0, sep_r}) + asr_w(my_r, {1'b0, ali_r});
          state_r <= S_LIMIT;
        end
        S_LIMIT: begin
          sh_r <= (speed != '0 && mg > {1'b0, maxs_r}) ? mg - {1'b0, maxs_r} : 6'd0;
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          ax_r <= asr_w(ax_r, sh_r);
          ay_r <= asr_w(ay_r, sh_r);
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (sx_r < EDGE_LOW_BOUND) ax_r <= ax_r + pushw;
          else if (sx_r > $signed({1'b0, right_r})) ax_r <= ax_r - pushw;
          if (sy_r < EDGE_LOW_BOUND) ay_r <= ay_r + pushw;
          else if (sy_r > $signed({1'b0, bottom_r})) ay_r <= ay_r - pushw;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          out_r <= {item_r.sel_index, sx_r + nvx, sy_r + nvy, nvx, nvy};
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !out_valid_r)
    else $error("transfer accepted while a result is pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("scan left early");
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_LOAD || state_r == S_WRITE))
    else $error("store written outside load or write-back");
endmodule

>>> rtl/bfu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfu_cell
// One slot of the nearest-neighbor insertion row. Keeps the smaller of its
// held candidate and the arriving one (equal distances go to the lower index)
// and hands the other to the next cell.
// ----------------------------------------------------------------------------
module bfu_cell (
  input  logic           clk,
  input  logic           clear,
  input  bfu_pkg::cand_t cand_in,
  output bfu_pkg::cand_t cand_out,
  output bfu_pkg::cand_t held
);
  import bfu_pkg::*;

  cand_t held_r, held_nxt, out_r, out_nxt;

  always_comb begin
    held_nxt = held_r;
    out_nxt  = cand_in;
    if (cand_in.valid) begin
      if (!held_r.valid || cand_in.gap < held_r.gap ||
          (cand_in.gap == held_r.gap && cand_in.id < held_r.id)) begin
        held_nxt = cand_in;
        out_nxt  = held_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      held_r <= '0;
      out_r  <= '0;
    end else begin
      held_r <= held_nxt;
      out_r  <= out_nxt;
    end
  end

  assign cand_out = out_r;
  assign held     = held_r;
endmodule

>>> tb/sv/boid_flocking_update_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boid_flocking_update_test
// Loads every boid, then drives directed and random load/update transfers
// through several register settings. A scoreboard keeps its own copy of the
// boid store and registers, predicts each result and checks it field by field.
// ----------------------------------------------------------------------------
module boid_flocking_update_test;
  import bfu_pkg::*;

  localparam int NBOIDS    = BOID_COUNT_DEF;
  localparam int NNEAR     = NEIGHBOR_COUNT_DEF;
  localparam int LIMIT     = 2000000;
  localparam int DRAIN_CYC = 300;

  class flock_board;
    int          pos_x[NBOIDS];
    int          pos_y[NBOIDS];
    int          vel_x[NBOIDS];
    int          vel_y[NBOIDS];
    logic [30:0] regs[8];
    out_item_t   pending_q[$];
    int          errors;
    int          checked;

    function new();
      errors  = 0;
      checked = 0;
      regs[REG_COH]    = 31'd6;
      regs[REG_SEP]    = 31'd4;
      regs[REG_ALI]    = 31'd2;
      regs[REG_MAXS]   = 31'd22;
      regs[REG_RAD]    = 31'd10485760;
      regs[REG_PUSH]   = 31'd1048576;
      regs[REG_RIGHT]  = 31'd637534208;
      regs[REG_BOTTOM] = 31'd469762048;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_COH, REG_SEP, REG_ALI, REG_MAXS: regs[idx] = 31'(val[4:0]);
        REG_PUSH: regs[idx] = 31'(val[23:0]);
        default: regs[idx] = val;
      endcase
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function int log2_floor(longint v);
      int r;
      r = 0;
      while (v > 1) begin
        v = v >>> 1;
        r++;
      end
      return r;
    endfunction

    function void steer(int i);
      longint x, y, ax, ay, cx, cy, rx, ry, mx, my, d, speed, nx, ny;
      longint near_d[NNEAR];
      int     near_id[NNEAR];
      int     cnt, k, m, mg;
      x = pos_x[i];
      y = pos_y[i];
      ax = vel_x[i];
      ay = vel_y[i];
      cx = 0; cy = 0; rx = 0; ry = 0; mx = 0; my = 0;
      cnt = 0;
      for (int j = 0; j < NBOIDS; j++) begin
        d = mag(x - longint'(pos_x[j])) + mag(y - longint'(pos_y[j]));
        k = 0;
        while (k < cnt && near_d[k] <= d) k++;
        if (k < NNEAR) begin
          m = (cnt < NNEAR) ? cnt : NNEAR - 1;
          for (; m > k; m--) begin
            near_id[m] = near_id[m-1];
            near_d[m]  = near_d[m-1];
          end
          near_id[k] = j;
          near_d[k]  = d;
          if (cnt < NNEAR) cnt++;
        end
      end
      for (k = 0; k < cnt; k++) begin
        nx = pos_x[near_id[k]];
        ny = pos_y[near_id[k]];
        cx += nx >>> 2;
        cy += ny >>> 2;
        if (near_d[k] < longint'(regs[REG_RAD])) begin
          rx += x - nx;
          ry += y - ny;
        end
        mx += longint'(vel_x[near_id[k]]) >>> 2;
        my += longint'(vel_y[near_id[k]]) >>> 2;
      end
      ax += (cx - x) >>> regs[REG_COH][4:0];
      ay += (cy - y) >>> regs[REG_COH][4:0];
      ax += rx >>> regs[REG_SEP][4:0];
      ay += ry >>> regs[REG_SEP][4:0];
      ax += mx >>> regs[REG_ALI][4:0];
      ay += my >>> regs[REG_ALI][4:0];
      speed = mag(ax) + mag(ay);
      if (speed > 0) begin
        mg = log2_floor(speed);
        if (mg > int'(regs[REG_MAXS])) begin
          ax = ax >>> (mg - int'(regs[REG_MAXS]));
          ay = ay >>> (mg - int'(regs[REG_MAXS]));
        end
      end
      if (x < longint'(EDGE_LOW_BOUND)) ax += longint'(regs[REG_PUSH]);
      else if (x > longint'(regs[REG_RIGHT])) ax -= longint'(regs[REG_PUSH]);
      if (y < longint'(EDGE_LOW_BOUND)) ay += longint'(regs[REG_PUSH]);
      else if (y > longint'(regs[REG_BOTTOM])) ay -= longint'(regs[REG_PUSH]);
      vel_x[i] = int'(ax[31:0]);
      vel_y[i] = int'(ay[31:0]);
      pos_x[i] = pos_x[i] + vel_x[i];
      pos_y[i] = pos_y[i] + vel_y[i];
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t e;
      int i;
      i = int'(it.sel_index);
      if (it.func == FUNC_LOAD) begin
        pos_x[i] = it.load_pos_x;
        pos_y[i] = it.load_pos_y;
        vel_x[i] = it.load_vel_x;
        vel_y[i] = it.load_vel_y;
      end else begin
        steer(i);
      end
      e.out_index = it.sel_index;
      e.new_pos_x = pos_x[i];
      e.new_pos_y = pos_y[i];
      e.new_vel_x = vel_x[i];
      e.new_vel_y = vel_y[i];
      pending_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = pending_q.pop_front();
      if (got.out_index !== e.out_index || got.new_pos_x !== e.new_pos_x ||
          got.new_pos_y !== e.new_pos_y || got.new_vel_x !== e.new_vel_x ||
          got.new_vel_y !== e.new_vel_y) begin
        errors++;
        if (errors <= 10)
          $display("mismatch boid %0d: exp pos %h,%h vel %h,%h got idx %0d pos %h,%h vel %h,%h",
                   e.out_index, e.new_pos_x, e.new_pos_y, e.new_vel_x, e.new_vel_y,
                   got.out_index, got.new_pos_x, got.new_pos_y, got.new_vel_x, got.new_vel_y);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfu_in_if  in_ch ();
  bfu_out_if out_ch ();

  boid_flocking_update u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  flock_board board;
  bit  quiet;
  int  hold_cycles;
  int  stall_left;
  int  cycles;
  int  n_loads, n_updates, n_settings;
  int  cluster_x[8];
  int  cluster_y[8];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    board         = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    quiet         = 1'b0;
    hold_cycles   = 0;
    stall_left    = 0;
    cycles        = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[boid_flocking_update] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, long hold-off on request, checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic write_all(int coh, int sep, int ali, int maxs, int rad, int push,
                           int right, int bottom);
    write_reg(REG_COH, CFG_DATA_W'(coh));
    write_reg(REG_SEP, CFG_DATA_W'(sep));
    write_reg(REG_ALI, CFG_DATA_W'(ali));
    write_reg(REG_MAXS, CFG_DATA_W'(maxs));
    write_reg(REG_RAD, CFG_DATA_W'(rad));
    write_reg(REG_PUSH, CFG_DATA_W'(push));
    write_reg(REG_RIGHT, CFG_DATA_W'(right));
    write_reg(REG_BOTTOM, CFG_DATA_W'(bottom));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic send(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    board.note_transfer(it);
    if (it.func == FUNC_LOAD) n_loads++;
    else n_updates++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic int pick_pos(int axis);
    int c;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1, 2, 3: return $urandom_range(0, 700000000);
      default: begin
        c = $urandom_range(0, 7);
        if ($urandom_range(0, 5) == 0) return axis ? cluster_y[c] : cluster_x[c];
        return (axis ? cluster_y[c] : cluster_x[c]) + $urandom_range(0, 8000000);
      end
    endcase
  endfunction

  function automatic int pick_vel();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 8000000) - 4000000;
  endfunction

  function automatic in_item_t load_item(int idx);
    in_item_t it;
    it.func       = FUNC_LOAD;
    it.sel_index  = IDX_W'(idx);
    it.load_pos_x = pick_pos(0);
    it.load_pos_y = pick_pos(1);
    it.load_vel_x = pick_vel();
    it.load_vel_y = pick_vel();
    return it;
  endfunction

  function automatic in_item_t update_item(int idx);
    in_item_t it;
    it            = '0;
    it.func       = FUNC_UPDATE;
    it.sel_index  = IDX_W'(idx);
    if ($urandom_range(0, 3) == 0) begin
      it.load_pos_x = $urandom;
      it.load_pos_y = $urandom;
      it.load_vel_x = $urandom;
      it.load_vel_y = $urandom;
    end
    return it;
  endfunction

  task automatic random_items(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 6) == 0) send(load_item($urandom_range(0, NBOIDS - 1)));
      else send(update_item($urandom_range(0, NBOIDS - 1)));
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    n_loads = 0; n_updates = 0; n_settings = 0;
    for (int c = 0; c < 8; c++) begin
      cluster_x[c] = $urandom_range(0, 680000000);
      cluster_y[c] = $urandom_range(0, 500000000);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_all(6, 4, 2, 22, 10485760, 1048576, 637534208, 469762048);

    // fill the store; a few boids at the extremes of the fields
    for (int i = 0; i < NBOIDS; i++) begin
      it = load_item(i);
      case (i)
        0: begin
          it.load_pos_x = 32'h7fffffff; it.load_pos_y = 32'h7fffffff;
          it.load_vel_x = 32'h7fffffff; it.load_vel_y = 32'h7fffffff;
        end
        1: begin
          it.load_pos_x = 32'h80000000; it.load_pos_y = 32'h80000000;
          it.load_vel_x = 32'h80000000; it.load_vel_y = 32'h80000000;
        end
        2: begin
          it.load_pos_x = '0; it.load_pos_y = '0; it.load_vel_x = '0; it.load_vel_y = '0;
        end
        3: begin
          it.load_pos_x = 32'hffffffff; it.load_pos_y = 32'hffffffff;
          it.load_vel_x = 32'hffffffff; it.load_vel_y = 32'hffffffff;
        end
        4, 5: begin
          it.load_pos_x = 300000000; it.load_pos_y = 200000000;
          it.load_vel_x = 0; it.load_vel_y = 0;
        end
        6: begin
          it.load_pos_x = 33554432; it.load_pos_y = 469762048;
        end
        7: begin
          it.load_pos_x = 637534209; it.load_pos_y = 33554431;
        end
        8: begin
          it.load_pos_x = 637534208; it.load_pos_y = 469762049;
        end
        default: ;
      endcase
      send(it);
    end
    in_ch.valid <= 1'b0;
    drain();

    // directed updates: extremes, ties, bounds, zero state
    for (int i = 0; i < 10; i++) send(update_item(i));
    send(update_item(NBOIDS - 1));
    send(load_item(NBOIDS - 1));
    send(update_item(NBOIDS - 1));
    send(update_item(0));
    in_ch.valid <= 1'b0;
    drain();

    random_items(280);
    drain();

    write_all(0, 0, 0, 0, 0, 0, 0, 0);
    random_items(140);
    drain();

    write_all(31, 31, 31, 30, 31'h7fffffff, 24'hffffff, 31'h7fffffff, 31'h7fffffff);
    random_items(140);
    drain();

    write_all($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 30), $urandom_range(0, 40000000), $urandom_range(0, 24'hffffff),
              $urandom_range(0, 700000000), $urandom_range(0, 500000000));
    random_items(100);
    hold_cycles = 400;
    random_items(130);
    drain();

    write_all(6, 4, 2, 22, 10485760, 1048576, 637534208, 469762048);
    quiet = 1'b1;
    random_items(230);
    drain();

    $display("covered %0d loads and %0d updates, %0d results checked, %0d register settings",
             n_loads, n_updates, board.checked, n_settings);
    $display("mismatches %0d, results still outstanding %0d",
             board.errors, board.pending_q.size());
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("[boid_flocking_update] OK");
    end else begin
      $display("[boid_flocking_update] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bfu_pkg.sv
rtl/bfu_if.sv
rtl/bfu_cell.sv
rtl/boid_flocking_update.sv
tb/sv/boid_flocking_update_test.sv
